// ----- src/spt_pkg.sv -----
// Shared constants, types and register codes for the polynomial temperature block.
// Used by the stream interfaces, the Horner multiplier, the divider and the top level.
`default_nettype none

package spt_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int IDX_W   = 3;
    localparam int TEMP_W  = 23;

    // Horner accumulator: signed, 16 fraction bits, magnitude below 2^35
    localparam int ACC_W   = 36;
    localparam int MAG_W   = 35;
    localparam int OPB_W   = 31;
    localparam int MLO_W   = 18;
    localparam int MHI_W   = 17;
    localparam int PL_W    = 49;
    localparam int PH_W    = 48;
    localparam int XW      = 67;
    localparam int STEP_LO = 13;
    localparam int LAST_LO = 26;

    // Constant divider by 3125, one 16-bit digit per two stages
    localparam int NUM_W   = 47;
    localparam int QUO_W   = 36;
    localparam int Q2_W    = 4;
    localparam int DCH_W   = 16;
    localparam int DY_W    = 28;
    localparam int DREC_W  = 29;
    localparam int DPROD_W = 57;
    localparam int DREM_W  = 12;
    localparam int DSHIFT  = 40;
    localparam logic [DREC_W-1:0] DIV_RECIP = 29'd351843721;
    localparam logic [DREM_W-1:0] DIV_D     = 12'd3125;

    // Rounding offsets: half of 2^13*3125, and 125 times half of 2^26*25
    localparam logic [XW-1:0] HALF_STEP = 67'd12800000;
    localparam logic [XW-1:0] HALF_LAST = 67'd104857600000;

    // Pipeline structure
    localparam int HORNER_STEPS = 4;
    localparam int MUL_STAGES   = 4;
    localparam int DIV_STAGES   = 6;

    // Output stage
    localparam int TSUM_W    = 38;
    localparam int KNEG_W    = 25;
    localparam int K0_SCALE  = 150;
    localparam logic signed [TEMP_W-1:0] T_MAX = 23'sd3000000;
    localparam logic signed [TEMP_W-1:0] T_MIN = -23'sd3000000;

    typedef enum logic [IDX_W-1:0] {
        CFG_K0 = 3'd0,
        CFG_K1 = 3'd1,
        CFG_K2 = 3'd2,
        CFG_K3 = 3'd3,
        CFG_K4 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] raw;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        t_side            side;
    } t_num;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        t_side            side;
    } t_quo;

endpackage

`default_nettype wire

// ----- src/spt_in_if.sv -----
// Input stream interface carrying one raw sensor reading per transaction.
// Depends on spt_pkg for the field width.
`default_nettype none

interface spt_in_if;
    logic                        valid;
    logic                        ready;
    logic [spt_pkg::RAW_W-1:0]   raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

`default_nettype wire

// ----- src/spt_out_if.sv -----
// Output stream interface carrying one calibrated temperature per transaction.
// Depends on spt_pkg for the field width.
`default_nettype none

interface spt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [spt_pkg::TEMP_W-1:0]  temperature_e4;
    logic                               valid_res;

    modport source (output valid, output temperature_e4, output valid_res, input ready);
    modport sink   (input valid, input temperature_e4, input valid_res, output ready);
endinterface

`default_nettype wire

// ----- src/spt_cfg_if.sv -----
// Configuration write interface: register index and write data per transaction.
// Depends on spt_pkg for the field widths.
`default_nettype none

interface spt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [spt_pkg::IDX_W-1:0]    index;
    logic [spt_pkg::COEF_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/spt_horner_mul.sv -----
// One Horner step front end: accumulate, take the magnitude, multiply by the reading
// and add the rounding offset. Four register stages. Depends on spt_pkg.
`default_nettype none

module spt_horner_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_last,
    input  wire logic signed [spt_pkg::ACC_W-1:0]   i_term,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire spt_pkg::t_quo                      i_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output spt_pkg::t_num                           o_data
);

    logic [spt_pkg::MUL_STAGES-1:0] r_vld;
    logic [spt_pkg::MUL_STAGES-1:0] ld;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        ld[spt_pkg::MUL_STAGES-1] = !r_vld[spt_pkg::MUL_STAGES-1] || i_ready;
        for (int k = spt_pkg::MUL_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < spt_pkg::MUL_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: add the signed rounded quotient of the previous step to the coefficient term.
    logic signed [spt_pkg::ACC_W-1:0] q_s;
    logic signed [spt_pkg::ACC_W-1:0] n_acc;
    logic signed [spt_pkg::ACC_W-1:0] r_acc;
    logic [spt_pkg::RAW_W-1:0]        r_raw0;

    assign q_s   = $signed({1'b0, i_data.quo[spt_pkg::QUO_W-2:0]});
    assign n_acc = i_data.side.neg ? (i_term - q_s) : (i_term + q_s);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_acc  <= n_acc;
            r_raw0 <= i_data.side.raw;
        end
    end

    // Stage 1: sign and magnitude; the last step multiplies by 125 times the reading.
    logic [spt_pkg::ACC_W-1:0] n_mag;
    logic [spt_pkg::OPB_W-1:0] n_opb;
    logic                      r_neg1;
    logic [spt_pkg::MAG_W-1:0] r_mag;
    logic [spt_pkg::OPB_W-1:0] r_opb;
    logic [spt_pkg::RAW_W-1:0] r_raw1;

    assign n_mag = r_acc[spt_pkg::ACC_W-1] ? (spt_pkg::ACC_W'(0) - r_acc) : r_acc;
    assign n_opb = i_last ? ({r_raw0, 7'b0} - {6'b0, r_raw0, 1'b0} - {7'b0, r_raw0})
                          : {7'b0, r_raw0};

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_neg1 <= r_acc[spt_pkg::ACC_W-1];
            r_mag  <= n_mag[spt_pkg::MAG_W-1:0];
            r_opb  <= n_opb;
            r_raw1 <= r_raw0;
        end
    end

    // Stage 2: two partial products of the magnitude and the operand.
    logic [spt_pkg::PL_W-1:0]  r_pl;
    logic [spt_pkg::PH_W-1:0]  r_ph;
    logic                      r_neg2;
    logic [spt_pkg::RAW_W-1:0] r_raw2;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_pl   <= spt_pkg::PL_W'(r_mag[spt_pkg::MLO_W-1:0]) * spt_pkg::PL_W'(r_opb);
            r_ph   <= spt_pkg::PH_W'(r_mag[spt_pkg::MAG_W-1:spt_pkg::MLO_W])
                      * spt_pkg::PH_W'(r_opb);
            r_neg2 <= r_neg1;
            r_raw2 <= r_raw1;
        end
    end

    // Stage 3: sum, rounding offset, and the power-of-two part of the divisor.
    logic [spt_pkg::XW-1:0] n_x;
    spt_pkg::t_num          r_out;

    assign n_x = spt_pkg::XW'({r_ph, {spt_pkg::MLO_W{1'b0}}}) + spt_pkg::XW'(r_pl)
                 + (i_last ? spt_pkg::HALF_LAST : spt_pkg::HALF_STEP);

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_out.num      <= i_last
                ? spt_pkg::NUM_W'(n_x[spt_pkg::XW-1:spt_pkg::LAST_LO])
                : n_x[spt_pkg::STEP_LO+spt_pkg::NUM_W-1:spt_pkg::STEP_LO];
            r_out.side.neg <= r_neg2;
            r_out.side.raw <= r_raw2;
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_vld[spt_pkg::MUL_STAGES-1];
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- src/spt_div3125.sv -----
// Pipelined constant divider by 3125: three 16-bit quotient digits, each found by a
// reciprocal multiply in two stages; a remainder feeds the next. Depends on spt_pkg.
`default_nettype none

module spt_div3125 (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire spt_pkg::t_num   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output spt_pkg::t_quo        o_data
);

    logic [spt_pkg::DIV_STAGES-1:0] r_vld;
    logic [spt_pkg::DIV_STAGES-1:0] ld;

    always_comb begin
        ld[spt_pkg::DIV_STAGES-1] = !r_vld[spt_pkg::DIV_STAGES-1] || i_ready;
        for (int k = spt_pkg::DIV_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < spt_pkg::DIV_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // For y below 3125*2^16, (y * DIV_RECIP) >> 40 is exactly y / 3125.
    logic [spt_pkg::DY_W-1:0]        y0;
    logic [spt_pkg::DPROD_W-1:0]     r_p0;
    logic [spt_pkg::DY_W-1:0]        r_y0;
    logic [2*spt_pkg::DCH_W-1:0]     r_lo0;
    spt_pkg::t_side                  r_side0;

    assign y0 = spt_pkg::DY_W'(i_data.num[spt_pkg::NUM_W-1:2*spt_pkg::DCH_W]);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_p0    <= spt_pkg::DPROD_W'(y0) * spt_pkg::DPROD_W'(spt_pkg::DIV_RECIP);
            r_y0    <= y0;
            r_lo0   <= i_data.num[2*spt_pkg::DCH_W-1:0];
            r_side0 <= i_data.side;
        end
    end

    // Top digit and its remainder.
    logic [spt_pkg::DCH_W-1:0]   q2;
    logic [spt_pkg::DY_W-1:0]    rem1;
    logic [spt_pkg::DY_W-1:0]    r_y1;
    logic [spt_pkg::Q2_W-1:0]    r_q2_1;
    logic [spt_pkg::DCH_W-1:0]   r_lo1;
    spt_pkg::t_side              r_side1;

    assign q2   = r_p0[spt_pkg::DSHIFT+spt_pkg::DCH_W-1:spt_pkg::DSHIFT];
    assign rem1 = r_y0 - spt_pkg::DY_W'(spt_pkg::DY_W'(q2) * spt_pkg::DY_W'(spt_pkg::DIV_D));

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_y1    <= {rem1[spt_pkg::DREM_W-1:0], r_lo0[2*spt_pkg::DCH_W-1:spt_pkg::DCH_W]};
            r_q2_1  <= q2[spt_pkg::Q2_W-1:0];
            r_lo1   <= r_lo0[spt_pkg::DCH_W-1:0];
            r_side1 <= r_side0;
        end
    end

    logic [spt_pkg::DPROD_W-1:0] r_p2;
    logic [spt_pkg::DY_W-1:0]    r_y2;
    logic [spt_pkg::Q2_W-1:0]    r_q2_2;
    logic [spt_pkg::DCH_W-1:0]   r_lo2;
    spt_pkg::t_side              r_side2;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_p2    <= spt_pkg::DPROD_W'(r_y1) * spt_pkg::DPROD_W'(spt_pkg::DIV_RECIP);
            r_y2    <= r_y1;
            r_q2_2  <= r_q2_1;
            r_lo2   <= r_lo1;
            r_side2 <= r_side1;
        end
    end

    // Middle digit and its remainder.
    logic [spt_pkg::DCH_W-1:0]   q1;
    logic [spt_pkg::DY_W-1:0]    rem3;
    logic [spt_pkg::DY_W-1:0]    r_y3;
    logic [spt_pkg::Q2_W-1:0]    r_q2_3;
    logic [spt_pkg::DCH_W-1:0]   r_q1_3;
    spt_pkg::t_side              r_side3;

    assign q1   = r_p2[spt_pkg::DSHIFT+spt_pkg::DCH_W-1:spt_pkg::DSHIFT];
    assign rem3 = r_y2 - spt_pkg::DY_W'(spt_pkg::DY_W'(q1) * spt_pkg::DY_W'(spt_pkg::DIV_D));

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_y3    <= {rem3[spt_pkg::DREM_W-1:0], r_lo2};
            r_q2_3  <= r_q2_2;
            r_q1_3  <= q1;
            r_side3 <= r_side2;
        end
    end

    logic [spt_pkg::DPROD_W-1:0] r_p4;
    logic [spt_pkg::Q2_W-1:0]    r_q2_4;
    logic [spt_pkg::DCH_W-1:0]   r_q1_4;
    spt_pkg::t_side              r_side4;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_p4    <= spt_pkg::DPROD_W'(r_y3) * spt_pkg::DPROD_W'(spt_pkg::DIV_RECIP);
            r_q2_4  <= r_q2_3;
            r_q1_4  <= r_q1_3;
            r_side4 <= r_side3;
        end
    end

    // Low digit; the remainder is not needed.
    spt_pkg::t_quo r_out;

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_out.quo  <= {r_q2_4, r_q1_4,
                           r_p4[spt_pkg::DSHIFT+spt_pkg::DCH_W-1:spt_pkg::DSHIFT]};
            r_out.side <= r_side4;
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_vld[spt_pkg::DIV_STAGES-1];
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- src/sensor_poly_temperature.sv -----
// Top level of the fourth-order polynomial temperature calibration pipeline.
// Depends on spt_pkg, the three stream interfaces, spt_horner_mul and spt_div3125.
//
//   Port    Direction  Transaction carries
//   i_in    sink       raw_reading (24 bits, 16.8 unsigned)
//   o_out   source     temperature_e4 (23 bits signed, 1e-4 degree), valid_res
//   i_cfg   sink       index (3 bits), data (16 bits); always ready
//
// One reading enters per cycle while i_in.ready is high; each result passes four Horner
// steps of four multiplier and six divider stages each, then the output register.
// The constant divider by 3125 and the partial-product multipliers set the stage count.
// Synchronous active-low reset empties the pipeline and clears all coefficients to zero.
// A full stage holds while the next one is full and held; empty stages fill behind it,
// so i_in.ready drops only when every stage is occupied and o_out is stalled.
`default_nettype none

module sensor_poly_temperature (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    spt_in_if.sink       i_in,
    spt_out_if.source    o_out,
    spt_cfg_if.sink      i_cfg
);

    // Coefficient registers, kept in the scaled form the datapath uses.
    logic signed [spt_pkg::ACC_W-1:0]   r_term4;
    logic signed [spt_pkg::ACC_W-1:0]   r_term3;
    logic signed [spt_pkg::ACC_W-1:0]   r_term2;
    logic signed [spt_pkg::ACC_W-1:0]   r_term1;
    logic signed [spt_pkg::KNEG_W-1:0]  r_kneg;
    logic [spt_pkg::HORNER_STEPS:0]     r_nz;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term4 <= '0;
            r_term3 <= '0;
            r_term2 <= '0;
            r_term1 <= '0;
            r_kneg  <= '0;
            r_nz    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                spt_pkg::CFG_K0: begin
                    r_kneg <= spt_pkg::KNEG_W'(0)
                              - spt_pkg::KNEG_W'(spt_pkg::KNEG_W'(i_cfg.data)
                                                 * spt_pkg::KNEG_W'(spt_pkg::K0_SCALE));
                    r_nz[0] <= |i_cfg.data;
                end
                spt_pkg::CFG_K1: begin
                    r_term1 <= spt_pkg::ACC_W'({i_cfg.data, 16'b0});
                    r_nz[1] <= |i_cfg.data;
                end
                spt_pkg::CFG_K2: begin
                    r_term2 <= spt_pkg::ACC_W'(0) - spt_pkg::ACC_W'({i_cfg.data, 17'b0});
                    r_nz[2] <= |i_cfg.data;
                end
                spt_pkg::CFG_K3: begin
                    r_term3 <= spt_pkg::ACC_W'({i_cfg.data, 18'b0});
                    r_nz[3] <= |i_cfg.data;
                end
                spt_pkg::CFG_K4: begin
                    r_term4 <= spt_pkg::ACC_W'(0) - spt_pkg::ACC_W'({i_cfg.data, 17'b0});
                    r_nz[4] <= |i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Horner chain: multiplier front end then divider, four times.
    spt_pkg::t_quo                      mq [spt_pkg::HORNER_STEPS+1];
    logic [spt_pkg::HORNER_STEPS:0]     vq;
    logic [spt_pkg::HORNER_STEPS:0]     rq;
    spt_pkg::t_num                      dn [spt_pkg::HORNER_STEPS];
    logic [spt_pkg::HORNER_STEPS-1:0]   vn;
    logic [spt_pkg::HORNER_STEPS-1:0]   rn;
    logic signed [spt_pkg::ACC_W-1:0]   term [spt_pkg::HORNER_STEPS];

    assign term[0] = r_term4;
    assign term[1] = r_term3;
    assign term[2] = r_term2;
    assign term[3] = r_term1;

    assign mq[0].quo      = '0;
    assign mq[0].side.neg = 1'b0;
    assign mq[0].side.raw = i_in.raw_reading;
    assign vq[0]          = i_in.valid;
    assign i_in.ready     = rq[0];

    for (genvar s = 0; s < spt_pkg::HORNER_STEPS; s++) begin : g_step
        spt_horner_mul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_last  (s == spt_pkg::HORNER_STEPS - 1),
            .i_term  (term[s]),
            .i_valid (vq[s]),
            .o_ready (rq[s]),
            .i_data  (mq[s]),
            .o_valid (vn[s]),
            .i_ready (rn[s]),
            .o_data  (dn[s])
        );

        spt_div3125 u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vn[s]),
            .o_ready (rn[s]),
            .i_data  (dn[s]),
            .o_valid (vq[s+1]),
            .i_ready (rq[s+1]),
            .o_data  (mq[s+1])
        );
    end

    // Output stage: apply sign, constant term, saturation and the validity rule.
    logic signed [spt_pkg::TSUM_W-1:0]  q_s;
    logic signed [spt_pkg::TSUM_W-1:0]  k_s;
    logic signed [spt_pkg::TSUM_W-1:0]  n_sum;
    logic                               n_ok;
    logic signed [spt_pkg::TEMP_W-1:0]  n_temp;
    logic                               r_out_valid;
    logic signed [spt_pkg::TEMP_W-1:0]  r_temp;
    logic                               r_vres;

    assign q_s   = $signed({2'b0, mq[spt_pkg::HORNER_STEPS].quo});
    assign k_s   = spt_pkg::TSUM_W'(r_kneg);
    assign n_sum = mq[spt_pkg::HORNER_STEPS].side.neg ? (k_s - q_s) : (k_s + q_s);
    assign n_ok  = (|mq[spt_pkg::HORNER_STEPS].side.raw) && (&r_nz);

    always_comb begin
        if (!n_ok) begin
            n_temp = spt_pkg::T_MIN;
        end else if (n_sum > spt_pkg::T_MAX) begin
            n_temp = spt_pkg::T_MAX;
        end else if (n_sum < spt_pkg::T_MIN) begin
            n_temp = spt_pkg::T_MIN;
        end else begin
            n_temp = n_sum[spt_pkg::TEMP_W-1:0];
        end
    end

    assign rq[spt_pkg::HORNER_STEPS] = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rq[spt_pkg::HORNER_STEPS]) begin
            r_out_valid <= vq[spt_pkg::HORNER_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rq[spt_pkg::HORNER_STEPS]) begin
            r_temp <= n_temp;
            r_vres <= n_ok;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.temperature_e4 = r_temp;
    assign o_out.valid_res      = r_vres;

    // Input backpressure can only come from a stalled, occupied output.
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a held output");

    a_invalid_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> (o_out.temperature_e4 == spt_pkg::T_MIN))
        else $error("invalid result not forced to the lower limit");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.temperature_e4 >= spt_pkg::T_MIN)
                         && (o_out.temperature_e4 <= spt_pkg::T_MAX)))
        else $error("temperature outside the saturation range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(vq[spt_pkg::HORNER_STEPS]))
        else $error("output became valid without a finished division");

endmodule

`default_nettype wire

// ----- tb/sv/sensor_poly_temperature_tb.sv -----
// Self-checking testbench for sensor_poly_temperature: drives raw readings and coefficient
// writes, predicts each calibrated temperature and compares it with the block's result.
// Depends on spt_pkg, spt_in_if, spt_out_if, spt_cfg_if and the sensor_poly_temperature RTL.
`default_nettype none

module sensor_poly_temperature_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spt_pkg::*;

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam longint TEMP_LIMIT  = 3000000;
    localparam longint HORNER_DIV  = 25600000;
    localparam longint OUTPUT_DIV  = 1677721600;
    localparam longint K0_WEIGHT   = 150;
    localparam longint Q16_ONE     = 65536;
    localparam int MAX_WAIT        = 17;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 90;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_SETTINGS = 20;
    localparam int RANDOM_BATCH    = 50;
    localparam int HOLD_BATCH      = 120;
    localparam int HOLD_SETTING    = 3;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
        logic [RAW_W-1:0]         raw;
    } t_temp_expect;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spt_in_if  in_bus ();
    spt_out_if out_bus ();
    spt_cfg_if cfg_bus ();

    sensor_poly_temperature DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // Coefficient copy used by the predictor, updated on each accepted write to K0..K4.
    logic [COEF_W-1:0] coef_regs [0:4];

    logic [RAW_W-1:0] raw_backlog [$];
    t_temp_expect     pending_temps [$];

    int  pushed_count;
    int  accepted_count;
    int  results_seen;
    int  mismatches;
    int  cycle_count;
    int  settings_used;
    int  flagged_invalid;
    int  clipped_high;
    int  clipped_low;
    int  tx_gap;
    int  rx_wait;
    bit  tx_gaps_on;
    bit  rx_gaps_on;
    bit  hold_go;
    logic long_hold;

    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic t_temp_expect calibrate_reading(logic [RAW_W-1:0] raw);
        t_temp_expect r;
        longint x;
        longint acc;
        longint t;
        x = longint'(raw);
        r.raw = raw;
        r.ok = raw != '0 && coef_regs[CFG_K0] != '0 && coef_regs[CFG_K1] != '0 &&
               coef_regs[CFG_K2] != '0 && coef_regs[CFG_K3] != '0 &&
               coef_regs[CFG_K4] != '0;
        if (!r.ok) begin
            t = -TEMP_LIMIT;
        end else begin
            acc = -2 * longint'(coef_regs[CFG_K4]) * Q16_ONE;
            acc = 4 * longint'(coef_regs[CFG_K3]) * Q16_ONE + round_div(acc * x, HORNER_DIV);
            acc = -2 * longint'(coef_regs[CFG_K2]) * Q16_ONE + round_div(acc * x, HORNER_DIV);
            acc = longint'(coef_regs[CFG_K1]) * Q16_ONE + round_div(acc * x, HORNER_DIV);
            t = round_div(acc * x, OUTPUT_DIV) - K0_WEIGHT * longint'(coef_regs[CFG_K0]);
            if (t > TEMP_LIMIT)
                t = TEMP_LIMIT;
            if (t < -TEMP_LIMIT)
                t = -TEMP_LIMIT;
        end
        r.temp = TEMP_W'(t);
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] draw_coef();
        case ($urandom_range(0, 9))
            0: return COEF_W'(1);
            1: return {COEF_W{1'b1}};
            2, 3, 4: return COEF_W'($urandom_range(1, (1 << COEF_W) - 1));
            default: return COEF_W'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] draw_reading();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return RAW_W'($urandom_range(1, 255));
            2, 3, 4: return RAW_W'($urandom_range(256, 65535));
            5, 6: return RAW_W'($urandom_range(24'hF00000, RAW_MAX));
            default: return RAW_W'($urandom_range(0, RAW_MAX));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic queue_reading(input logic [RAW_W-1:0] raw);
        raw_backlog.push_back(raw);
        pushed_count++;
    endtask

    // Called at a rising edge; leaves the channel valid so that a following
    // write can reuse it without a gap.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge i_clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        if (idx <= CFG_K4)
            coef_regs[idx] = data;
    endtask

    // Writes all five coefficients, then a number of unused indexes with zero data,
    // which must leave the coefficients untouched.
    task automatic load_coefs(input logic [COEF_W-1:0] vals [0:4], input int ignored);
        t_cfg_idx k;
        k = CFG_K0;
        for (int j = 0; j < 5; j++) begin
            write_reg(k, vals[j]);
            k = k.next();
        end
        for (int j = 0; j < ignored; j++)
            write_reg(IDX_W'(int'(CFG_K4) + 1 + j), '0);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Returns at a rising edge once every queued reading has been accepted and answered.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (accepted_count != pushed_count || results_seen != accepted_count);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_temps.size());
            $display("status: fail");
            $finish;
        end
    end

    // Input driver: one reading per transaction, with a drawn gap after each while tx_gaps_on.
    always @(posedge i_clk) begin : drive_readings
        logic slot_free;
        if (!i_rst_n) begin
            in_bus.valid       <= 1'b0;
            in_bus.raw_reading <= '0;
            tx_gap             <= 0;
        end else begin
            slot_free = !in_bus.valid;
            if (in_bus.valid && in_bus.ready) begin
                pending_temps.push_back(calibrate_reading(in_bus.raw_reading));
                accepted_count <= accepted_count + 1;
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (tx_gap != 0) begin
                    tx_gap       <= tx_gap - 1;
                    in_bus.valid <= 1'b0;
                end else if (raw_backlog.size() != 0) begin
                    in_bus.raw_reading <= raw_backlog.pop_front();
                    in_bus.valid       <= 1'b1;
                    tx_gap             <= tx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        int rx_next;
        t_temp_expect want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            rx_wait       <= 0;
        end else begin
            rx_next = rx_wait;
            if (out_bus.valid && out_bus.ready) begin
                results_seen <= results_seen + 1;
                if (pending_temps.size() == 0) begin
                    report_mismatch($sformatf("unexpected result temp=%0d ok=%0b",
                                              out_bus.temperature_e4, out_bus.valid_res));
                end else begin
                    want = pending_temps.pop_front();
                    if (out_bus.temperature_e4 !== want.temp)
                        report_mismatch($sformatf("raw=%06h temperature_e4=%0d want %0d",
                                                  want.raw, out_bus.temperature_e4,
                                                  want.temp));
                    if (out_bus.valid_res !== want.ok)
                        report_mismatch($sformatf("raw=%06h valid_res=%0b want %0b",
                                                  want.raw, out_bus.valid_res, want.ok));
                    if (!want.ok)
                        flagged_invalid++;
                    else if (want.temp == TEMP_W'(TEMP_LIMIT))
                        clipped_high++;
                    else if (want.temp == TEMP_W'(-TEMP_LIMIT))
                        clipped_low++;
                end
                rx_next = rx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (rx_next != 0) begin
                rx_next--;
            end
            rx_wait       <= rx_next;
            out_bus.ready <= rx_next == 0 && !long_hold;
        end
    end

    // Long receiver stall, so the pipeline fills up and pushes back on the input.
    initial begin
        long_hold <= 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        logic [COEF_W-1:0] vals [0:4];
        int batch;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= '0;
        cfg_bus.data       <= '0;
        i_rst_n            <= 1'b0;
        hold_go            = 1'b0;
        tx_gaps_on         = 1'b1;
        rx_gaps_on         = 1'b1;
        for (int j = 0; j < 5; j++)
            coef_regs[j] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficients are zero after reset, so nothing may come out flagged valid.
        @(negedge i_clk);
        queue_reading('0);
        queue_reading(RAW_W'(1));
        queue_reading(RAW_MAX);
        wait_drained();

        // Largest coefficients with extreme readings; unused indexes get zero data.
        for (int j = 0; j < 5; j++)
            vals[j] = {COEF_W{1'b1}};
        load_coefs(vals, 3);
        @(negedge i_clk);
        queue_reading('0);
        queue_reading(RAW_W'(1));
        queue_reading(24'h800000);
        queue_reading(RAW_MAX);
        queue_reading(24'h0000FF);
        queue_reading(24'hFFFF00);
        wait_drained();

        for (int j = 0; j < 5; j++)
            vals[j] = COEF_W'(1);
        load_coefs(vals, 0);
        @(negedge i_clk);
        queue_reading(RAW_W'(1));
        queue_reading(RAW_MAX);
        queue_reading(24'h5A5A5A);
        wait_drained();

        // Each coefficient zero in turn invalidates the result.
        for (int z = 0; z < 5; z++) begin
            for (int j = 0; j < 5; j++)
                vals[j] = COEF_W'($urandom_range(1, 4000));
            vals[z] = '0;
            load_coefs(vals, 0);
            @(negedge i_clk);
            queue_reading(RAW_W'($urandom_range(1, RAW_MAX)));
            queue_reading(RAW_W'($urandom_range(1, RAW_MAX)));
            wait_drained();
        end

        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            for (int j = 0; j < 5; j++)
                vals[j] = draw_coef();
            if ($urandom_range(0, 7) == 0)
                vals[$urandom_range(0, 4)] = '0;
            load_coefs(vals, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            @(negedge i_clk);
            if (p == HOLD_SETTING) begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
                batch = HOLD_BATCH;
            end else begin
                tx_gaps_on = $urandom_range(0, 2) != 0;
                rx_gaps_on = $urandom_range(0, 2) != 0;
                batch = RANDOM_BATCH;
            end
            for (int j = 0; j < batch; j++)
                queue_reading(draw_reading());
            if (p == HOLD_SETTING)
                hold_go = 1'b1;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_temps.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_temps.size()));

        $display("checked %0d readings under %0d coefficient sets, one long output stall",
                 results_seen, settings_used);
        $display("%0d flagged invalid, %0d clipped high, %0d clipped low, %0d mismatches",
                 flagged_invalid, clipped_high, clipped_low, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/spt_pkg.sv
src/spt_in_if.sv
src/spt_out_if.sv
src/spt_cfg_if.sv
src/spt_horner_mul.sv
src/spt_div3125.sv
src/sensor_poly_temperature.sv
tb/sv/sensor_poly_temperature_tb.sv
